@@ hdl/mwm_pkg.sv @@
// Package for the maze wall map engine.
// Request codes, direction codes, controller states and the command and
// status structs shared by the controller, datapath and top level.
package mwm_pkg;

  localparam int WALL_W = 8;

  localparam logic [2:0] REQ_UPDATE      = 3'd0;
  localparam logic [2:0] REQ_ADD_WALL    = 3'd1;
  localparam logic [2:0] REQ_REMOVE_WALL = 3'd2;
  localparam logic [2:0] REQ_SET_COST    = 3'd3;
  localparam logic [2:0] REQ_QUERY       = 3'd4;

  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  localparam logic [3:0] GOAL_RESET = 4'd7;

  localparam logic [2:0] QRY_LAST = 3'd4;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_WRD   = 7'b0000100,
    ST_WWR   = 7'b0001000,
    ST_CWR   = 7'b0010000,
    ST_QRY   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic wall_rd;
    logic wall_wr;
    logic cost_wr;
    logic qry_step;
    logic out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic wall_last;
    logic qry_last;
  } sts_t;

endpackage

@@ hdl/maze_wall_map_engine_unit.sv @@
// Top level of the maze wall map engine.
// Goal registers behind the APB port, controller and datapath.
// Depends on mwm_pkg, mwm_ctrl and mwm_datapath.
//
// After reset the block runs a clearing pass over all ROWS*COLS cells that lays
// down the boundary walls and zero costs; busy stays high until it ends.
// A request is taken on start while busy is low. Every request produces one
// result, strobed by valid_o for a single cycle; the receiver cannot stall
// it. Every request ends in the neighbour cost scan: set cost first writes
// the cost, add or remove wall first runs two read-modify-writes of the wall
// memory, one after the other, and update walls runs five of them. busy
// falls in the cycle after the strobe.
module maze_wall_map_engine_unit
  import mwm_pkg::*;
#(
  parameter int ROWS      = 16,
  parameter int COLS      = 16,
  parameter int COST_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [3:0]  cell_row_i,
  input  logic [3:0]  cell_col_i,
  input  logic [1:0]  wall_dir_i,
  input  logic [3:0]  wall_report_i,
  input  logic [15:0] cost_value_i,
  output logic        valid_o,
  output logic [3:0]  walls_present_o,
  output logic [3:0]  walls_seen_o,
  output logic        cell_visited_o,
  output logic        at_goal_o,
  output logic [1:0]  best_dir_o,
  output logic [15:0] best_cost_o
);

  logic [3:0] goal_row_q;
  logic [3:0] goal_col_q;
  logic       cfg_wr;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_row_q <= GOAL_RESET;
      goal_col_q <= GOAL_RESET;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        goal_col_q <= pwdata[3:0];
      end else begin
        goal_row_q <= pwdata[3:0];
      end
    end
  end

  assign prdata = paddr[2] ? {28'd0, goal_col_q} : {28'd0, goal_row_q};

  mwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  mwm_datapath #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .COST_BITS (COST_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .cell_row_i      (cell_row_i),
    .cell_col_i      (cell_col_i),
    .wall_dir_i      (wall_dir_i),
    .wall_report_i   (wall_report_i),
    .cost_value_i    (cost_value_i),
    .goal_row_i      (goal_row_q),
    .goal_col_i      (goal_col_q),
    .walls_present_o (walls_present_o),
    .walls_seen_o    (walls_seen_o),
    .cell_visited_o  (cell_visited_o),
    .at_goal_o       (at_goal_o),
    .best_dir_o      (best_dir_o),
    .best_cost_o     (best_cost_o)
  );

  assign valid_o = cmd.out;

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  a_result_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result shown while idle");

  a_rmw_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wall_wr |-> $past(cmd.wall_rd))
    else $error("wall write without preceding read");

endmodule

@@ hdl/mwm_ctrl.sv @@
// Controller of the maze wall map engine.
// One-hot sequencer: clearing pass, wall read-modify-write slots, cost write,
// neighbour cost scan and result strobe. Depends on mwm_pkg.
module mwm_ctrl
  import mwm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] req_type_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.load = start_i;
        if (start_i) begin
          case (req_type_i)
            REQ_UPDATE, REQ_ADD_WALL, REQ_REMOVE_WALL: state_d = ST_WRD;
            REQ_SET_COST: state_d = ST_CWR;
            default:      state_d = ST_QRY;
          endcase
        end
      end
      ST_WRD: begin
        cmd_o.wall_rd = 1'b1;
        state_d = ST_WWR;
      end
      ST_WWR: begin
        cmd_o.wall_wr = 1'b1;
        state_d = sts_i.wall_last ? ST_QRY : ST_WRD;
      end
      ST_CWR: begin
        cmd_o.cost_wr = 1'b1;
        state_d = ST_QRY;
      end
      ST_QRY: begin
        cmd_o.qry_step = 1'b1;
        if (sts_i.qry_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.out = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ hdl/mwm_datapath.sv @@
// Datapath of the maze wall map engine.
// Wall and cost memories, request registers, neighbour addressing, wall
// read-modify-write and least-cost neighbour scan. Depends on mwm_pkg.
module mwm_datapath
  import mwm_pkg::*;
#(
  parameter int ROWS      = 16,
  parameter int COLS      = 16,
  parameter int COST_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [2:0]  req_type_i,
  input  logic [3:0]  cell_row_i,
  input  logic [3:0]  cell_col_i,
  input  logic [1:0]  wall_dir_i,
  input  logic [3:0]  wall_report_i,
  input  logic [15:0] cost_value_i,
  input  logic [3:0]  goal_row_i,
  input  logic [3:0]  goal_col_i,
  output logic [3:0]  walls_present_o,
  output logic [3:0]  walls_seen_o,
  output logic        cell_visited_o,
  output logic        at_goal_o,
  output logic [1:0]  best_dir_o,
  output logic [15:0] best_cost_o
);

  localparam int CELLS = ROWS * COLS;
  localparam int IDX_W = $clog2(CELLS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);

  function automatic logic [6:0] wrap_mod(logic [3:0] v, int m);
    logic [6:0] r;
    r = {3'b000, v};
    for (int i = 0; i < 8; i++) begin
      if (int'(r) >= m) r = r - 7'(m);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] cell_idx(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return IDX_W'(int'(r) * COLS + int'(c));
  endfunction

  logic [WALL_W-1:0]    wall_mem [CELLS];
  logic [COST_BITS-1:0] cost_mem [CELLS];

  logic [2:0]           req_q;
  logic [ROW_W-1:0]     row_q;
  logic [COL_W-1:0]     col_q;
  logic [1:0]           dir_q;
  logic [3:0]           report_q;
  logic [COST_BITS-1:0] cost_q;
  logic [IDX_W-1:0]     own_idx_q;
  logic [IDX_W-1:0]     nbr_idx_q [4];
  logic [IDX_W-1:0]     nbr_idx_d [4];
  logic [4:0]           rem_q;
  logic [2:0]           qcnt_q;
  logic [ROW_W-1:0]     clr_row_q;
  logic [COL_W-1:0]     clr_col_q;
  logic [WALL_W-1:0]    wall_rd_q;
  logic [COST_BITS-1:0] cost_rd_q;
  logic [COST_BITS-1:0] best_cost_q;
  logic [1:0]           best_dir_q;

  logic [ROW_W-1:0]  row_v, row_n, row_s;
  logic [COL_W-1:0]  col_v, col_e, col_w;
  logic [4:0]        rem_v;
  logic [2:0]        slot_v;
  logic [1:0]        dsel_v;
  logic [1:0]        opp_v;
  logic [IDX_W-1:0]  slot_addr;
  logic [3:0]        mask_v, val_v;
  logic [WALL_W-1:0] wall_new;
  logic [WALL_W-1:0] wall_init;
  logic [3:0]        init_walls;
  logic [1:0]        qk_v;
  logic              add_v;
  logic              upd_v;

  logic              wall_we, wall_re;
  logic [IDX_W-1:0]  wall_waddr, wall_raddr;
  logic [WALL_W-1:0] wall_wdata;
  logic              cost_we, cost_re;
  logic [IDX_W-1:0]  cost_waddr, cost_raddr;
  logic [COST_BITS-1:0] cost_wdata;

  // neighbour cells of the incoming request, wrapping in both rows and columns
  always_comb begin
    row_v = ROW_W'(wrap_mod(cell_row_i, ROWS));
    col_v = COL_W'(wrap_mod(cell_col_i, COLS));
    row_n = (int'(row_v) == ROWS - 1) ? '0 : row_v + 1'b1;
    row_s = (row_v == '0) ? ROW_W'(ROWS - 1) : row_v - 1'b1;
    col_e = (int'(col_v) == COLS - 1) ? '0 : col_v + 1'b1;
    col_w = (col_v == '0) ? COL_W'(COLS - 1) : col_v - 1'b1;
    nbr_idx_d[DIR_NORTH] = cell_idx(row_n, col_v);
    nbr_idx_d[DIR_EAST]  = cell_idx(row_v, col_e);
    nbr_idx_d[DIR_SOUTH] = cell_idx(row_s, col_v);
    nbr_idx_d[DIR_WEST]  = cell_idx(row_v, col_w);
    case (req_type_i)
      REQ_UPDATE:                    rem_v = 5'b11111;
      REQ_ADD_WALL, REQ_REMOVE_WALL: rem_v = 5'b00001 | (5'b00010 << wall_dir_i);
      default:                       rem_v = 5'b00000;
    endcase
  end

  // lowest pending slot: 0 own cell, 1..4 neighbour per direction
  always_comb begin
    slot_v = 3'd0;
    for (int i = 4; i >= 0; i--) begin
      if (rem_q[i]) slot_v = 3'(i);
    end
    dsel_v = 2'(slot_v - 3'd1);
    opp_v  = dsel_v + 2'd2;
    slot_addr = (slot_v == 3'd0) ? own_idx_q : nbr_idx_q[dsel_v];
    add_v = (req_q == REQ_ADD_WALL);
    upd_v = (req_q == REQ_UPDATE);
    if (slot_v == 3'd0) begin
      mask_v = upd_v ? 4'hF : (4'b0001 << dir_q);
      val_v  = upd_v ? report_q : {4{add_v}};
    end else begin
      mask_v = 4'b0001 << opp_v;
      val_v  = upd_v ? {4{report_q[dsel_v]}} : {4{add_v}};
    end
    wall_new = {wall_rd_q[7:4] | mask_v, (wall_rd_q[3:0] & ~mask_v) | (val_v & mask_v)};
  end

  // reset map: boundary walls plus the east wall of the start cell
  always_comb begin
    init_walls[DIR_NORTH] = (int'(clr_row_q) == ROWS - 1);
    init_walls[DIR_SOUTH] = (clr_row_q == '0);
    init_walls[DIR_EAST]  = (int'(clr_col_q) == COLS - 1) ||
                            ((clr_row_q == '0) && (clr_col_q == '0));
    init_walls[DIR_WEST]  = (clr_col_q == '0) ||
                            ((clr_row_q == '0) && (int'(clr_col_q) == 1));
    wall_init = {init_walls, init_walls};
  end

  assign wall_we    = cmd_i.clr_step | cmd_i.wall_wr;
  assign wall_waddr = cmd_i.clr_step ? cell_idx(clr_row_q, clr_col_q) : slot_addr;
  assign wall_wdata = cmd_i.clr_step ? wall_init : wall_new;
  assign wall_re    = cmd_i.wall_rd | (cmd_i.qry_step && (qcnt_q == 3'd0));
  assign wall_raddr = cmd_i.wall_rd ? slot_addr : own_idx_q;

  assign cost_we    = cmd_i.clr_step | cmd_i.cost_wr;
  assign cost_waddr = cmd_i.clr_step ? cell_idx(clr_row_q, clr_col_q) : own_idx_q;
  assign cost_wdata = cmd_i.clr_step ? '0 : cost_q;
  assign cost_re    = cmd_i.qry_step && (qcnt_q != QRY_LAST);
  assign cost_raddr = nbr_idx_q[qcnt_q[1:0]];

  always_ff @(posedge clk_i) begin
    if (wall_we) wall_mem[wall_waddr] <= wall_wdata;
    if (wall_re) wall_rd_q <= wall_mem[wall_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cost_we) cost_mem[cost_waddr] <= cost_wdata;
    if (cost_re) cost_rd_q <= cost_mem[cost_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q <= '0;
      clr_col_q <= '0;
      rem_q     <= '0;
      qcnt_q    <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        if (int'(clr_col_q) == COLS - 1) begin
          clr_col_q <= '0;
          clr_row_q <= clr_row_q + 1'b1;
        end else begin
          clr_col_q <= clr_col_q + 1'b1;
        end
      end
      if (cmd_i.load) begin
        rem_q  <= rem_v;
        qcnt_q <= '0;
      end else begin
        if (cmd_i.wall_wr) rem_q <= rem_q & ~(5'b00001 << slot_v);
        if (cmd_i.qry_step) qcnt_q <= qcnt_q + 3'd1;
      end
    end
  end

  assign qk_v = 2'(qcnt_q - 3'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q     <= req_type_i;
      row_q     <= row_v;
      col_q     <= col_v;
      dir_q     <= wall_dir_i;
      report_q  <= wall_report_i;
      cost_q    <= COST_BITS'(cost_value_i);
      own_idx_q <= cell_idx(row_v, col_v);
      nbr_idx_q <= nbr_idx_d;
    end
    if (cmd_i.qry_step) begin
      if (qcnt_q == 3'd0) begin
        best_cost_q <= '1;
        best_dir_q  <= DIR_NORTH;
      end else if (!wall_rd_q[qk_v] && (cost_rd_q < best_cost_q)) begin
        best_cost_q <= cost_rd_q;
        best_dir_q  <= qk_v;
      end
    end
  end

  assign sts_o.clr_last  = (int'(clr_row_q) == ROWS - 1) && (int'(clr_col_q) == COLS - 1);
  assign sts_o.wall_last = ((rem_q & ~(5'b00001 << slot_v)) == 5'b00000);
  assign sts_o.qry_last  = (qcnt_q == QRY_LAST);

  assign walls_present_o = wall_rd_q[3:0];
  assign walls_seen_o    = wall_rd_q[7:4];
  assign cell_visited_o  = &wall_rd_q[7:4];
  assign at_goal_o       = (7'(row_q) == 7'(goal_row_i)) && (7'(col_q) == 7'(goal_col_i));
  assign best_dir_o      = best_dir_q;
  assign best_cost_o     = 16'(best_cost_q);

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for maze_wall_map_engine_unit: directed and random
// wall, cost and query requests with a cell-map predictor and APB goal writes.
// Depends on mwm_pkg and the maze_wall_map_engine_unit RTL.
module testbench
  import mwm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned PHASE_ITEMS   = 160;
  localparam logic [2:0]  ADDR_GOAL_ROW = 3'd0;
  localparam logic [2:0]  ADDR_GOAL_COL = 3'd4;
  localparam logic [2:0]  REQ_UNKNOWN_LO = REQ_QUERY + 3'd1;
  localparam logic [2:0]  REQ_UNKNOWN_HI = 3'd7;
  localparam logic [15:0] COST_TOP = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [1:0]  dir;
    logic [3:0]  report;
    logic [15:0] cost;
    logic        drain;
  } maze_req_t;

  typedef struct packed {
    logic [3:0]  walls;
    logic [3:0]  seen;
    logic        visited;
    logic        at_goal;
    logic [1:0]  dir;
    logic [15:0] cost;
  } cell_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [2:0]  req_type_i;
  logic [3:0]  cell_row_i;
  logic [3:0]  cell_col_i;
  logic [1:0]  wall_dir_i;
  logic [3:0]  wall_report_i;
  logic [15:0] cost_value_i;
  logic        valid_o;
  logic [3:0]  walls_present_o;
  logic [3:0]  walls_seen_o;
  logic        cell_visited_o;
  logic        at_goal_o;
  logic [1:0]  best_dir_o;
  logic [15:0] best_cost_o;

  logic [7:0]  map_walls [256];
  logic [15:0] map_costs [256];
  logic [3:0]  goal_row_q;
  logic [3:0]  goal_col_q;

  maze_req_t    pending_reqs [$];
  cell_report_t awaited_cells [$];
  maze_req_t    held_req;
  logic         tx_enable;
  logic         no_gaps;
  int unsigned  gap_left;
  logic [3:0]   win_row;
  logic [3:0]   win_col;
  int unsigned  quiet_cycles;
  int unsigned  errors;
  int unsigned  n_sent;
  int unsigned  n_checked;
  int unsigned  n_goal_hits;
  int unsigned  n_directed;

  maze_wall_map_engine_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .cell_row_i     (cell_row_i),
    .cell_col_i     (cell_col_i),
    .wall_dir_i     (wall_dir_i),
    .wall_report_i  (wall_report_i),
    .cost_value_i   (cost_value_i),
    .valid_o        (valid_o),
    .walls_present_o(walls_present_o),
    .walls_seen_o   (walls_seen_o),
    .cell_visited_o (cell_visited_o),
    .at_goal_o      (at_goal_o),
    .best_dir_o     (best_dir_o),
    .best_cost_o    (best_cost_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [7:0] neighbour_of(logic [3:0] row, logic [3:0] col,
                                              logic [1:0] dir);
    case (dir)
      DIR_NORTH: row = row + 4'd1;
      DIR_EAST:  col = col + 4'd1;
      DIR_SOUTH: row = row - 4'd1;
      default:   col = col - 4'd1;
    endcase
    return {row, col};
  endfunction

  function automatic void mark_wall(logic [3:0] row, logic [3:0] col, logic [1:0] dir,
                                    logic present);
    logic [7:0] idx;
    logic [7:0] nidx;
    logic [1:0] back;
    idx  = {row, col};
    nidx = neighbour_of(row, col, dir);
    back = dir + 2'd2;
    map_walls[idx][dir]      = present;
    map_walls[idx][dir + 4]  = 1'b1;
    map_walls[nidx][back]     = present;
    map_walls[nidx][back + 4] = 1'b1;
  endfunction

  function automatic void lay_boundary();
    for (int i = 0; i < 256; i++) begin
      map_walls[i] = '0;
      map_costs[i] = '0;
    end
    for (int r = 0; r < 16; r++) begin
      mark_wall(4'(r), 4'd0, DIR_WEST, 1'b1);
      mark_wall(4'(r), 4'd15, DIR_EAST, 1'b1);
    end
    for (int c = 0; c < 16; c++) begin
      mark_wall(4'd0, 4'(c), DIR_SOUTH, 1'b1);
      mark_wall(4'd15, 4'(c), DIR_NORTH, 1'b1);
    end
    mark_wall(4'd0, 4'd0, DIR_EAST, 1'b1);
  endfunction

  function automatic cell_report_t apply_request(maze_req_t r);
    cell_report_t res;
    logic [7:0]   w;
    logic [7:0]   nidx;
    case (r.kind)
      REQ_UPDATE: begin
        for (int k = 0; k < 4; k++) mark_wall(r.row, r.col, 2'(k), r.report[k]);
      end
      REQ_ADD_WALL:    mark_wall(r.row, r.col, r.dir, 1'b1);
      REQ_REMOVE_WALL: mark_wall(r.row, r.col, r.dir, 1'b0);
      REQ_SET_COST:    map_costs[{r.row, r.col}] = r.cost;
      default: ;
    endcase
    w = map_walls[{r.row, r.col}];
    res.walls   = w[3:0];
    res.seen    = w[7:4];
    res.visited = &w[7:4];
    res.at_goal = (r.row == goal_row_q) && (r.col == goal_col_q);
    res.dir     = DIR_NORTH;
    res.cost    = COST_TOP;
    for (int k = 0; k < 4; k++) begin
      if (!w[k]) begin
        nidx = neighbour_of(r.row, r.col, 2'(k));
        if (map_costs[nidx] < res.cost) begin
          res.cost = map_costs[nidx];
          res.dir  = 2'(k);
        end
      end
    end
    return res;
  endfunction

  function automatic void push_req(logic [2:0] kind, logic [3:0] row, logic [3:0] col,
                                   logic [1:0] dir, logic [3:0] report, logic [15:0] cost);
    maze_req_t r;
    r.kind   = kind;
    r.row    = row;
    r.col    = col;
    r.dir    = dir;
    r.report = report;
    r.cost   = cost;
    r.drain  = 1'b0;
    pending_reqs.push_back(r);
  endfunction

  function automatic maze_req_t random_req();
    maze_req_t   r;
    int unsigned pick;
    int unsigned area;
    pick = $urandom_range(99);
    if (pick < 20)      r.kind = REQ_UPDATE;
    else if (pick < 35) r.kind = REQ_ADD_WALL;
    else if (pick < 50) r.kind = REQ_REMOVE_WALL;
    else if (pick < 70) r.kind = REQ_SET_COST;
    else if (pick < 95) r.kind = REQ_QUERY;
    else                r.kind = 3'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO));
    area = $urandom_range(9);
    if (area == 0) begin
      r.row = goal_row_q;
      r.col = goal_col_q;
    end else if (area < 7) begin
      r.row = win_row + 4'($urandom_range(3));
      r.col = win_col + 4'($urandom_range(3));
    end else begin
      r.row = 4'($urandom_range(15));
      r.col = 4'($urandom_range(15));
    end
    r.dir    = 2'($urandom_range(3));
    r.report = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 25)      r.cost = COST_TOP;
    else if (pick < 50) r.cost = 16'($urandom_range(3));
    else                r.cost = 16'($urandom_range(65535));
    r.drain = ($urandom_range(49) == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic apb_transfer(input logic wr, input logic [2:0] addr, input logic [3:0] val);
    logic [31:0] data;
    data      = $urandom();
    data[3:0] = val;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (wr) begin
      if (addr == ADDR_GOAL_ROW) goal_row_q = val;
      else goal_col_q = val;
    end else begin
      check_field(addr == ADDR_GOAL_ROW ? "goal_row readback" : "goal_col readback",
                  {28'd0, addr == ADDR_GOAL_ROW ? goal_row_q : goal_col_q}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_reqs.size() != 0 || start || awaited_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // driver: hold each request until transfer, then idle for a random gap (none while no_gaps is set)
  always @(posedge clk_i) begin
    maze_req_t   nxt;
    int unsigned pick;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_cells.push_back(apply_request(held_req));
        n_sent++;
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (tx_enable && pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && awaited_cells.size() != 0)) begin
          nxt = pending_reqs.pop_front();
          held_req      = nxt;
          req_type_i    <= nxt.kind;
          cell_row_i    <= nxt.row;
          cell_col_i    <= nxt.col;
          wall_dir_i    <= nxt.dir;
          wall_report_i <= nxt.report;
          cost_value_i  <= nxt.cost;
          start         <= 1'b1;
          pick = $urandom_range(99);
          if (no_gaps || pick < 70) gap_left = 0;
          else if (pick < 95)       gap_left = $urandom_range(3, 1);
          else                      gap_left = $urandom_range(40, 8);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    cell_report_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (awaited_cells.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual walls %0h cost %0d",
                 $time, walls_present_o, best_cost_o);
      end else begin
        want = awaited_cells.pop_front();
        check_field("walls_present", want.walls, walls_present_o);
        check_field("walls_seen", want.seen, walls_seen_o);
        check_field("cell_visited", want.visited, cell_visited_o);
        check_field("at_goal", want.at_goal, at_goal_o);
        check_field("best_dir", want.dir, best_dir_o);
        check_field("best_cost", want.cost, best_cost_o);
        n_checked++;
        if (want.at_goal) n_goal_hits++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: watchdog expired, no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned g_row;
    int unsigned g_col;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    start         = 1'b0;
    req_type_i    = REQ_QUERY;
    cell_row_i    = '0;
    cell_col_i    = '0;
    wall_dir_i    = DIR_NORTH;
    wall_report_i = '0;
    cost_value_i  = '0;
    tx_enable     = 1'b0;
    no_gaps       = 1'b0;
    gap_left      = 0;
    quiet_cycles  = 0;
    errors        = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_goal_hits   = 0;
    win_row       = 4'd6;
    win_col       = 4'd6;
    goal_row_q    = GOAL_RESET;
    goal_col_q    = GOAL_RESET;
    lay_boundary();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);

    apb_transfer(1'b0, ADDR_GOAL_ROW, 4'd0);
    apb_transfer(1'b0, ADDR_GOAL_COL, 4'd0);

    push_req(REQ_QUERY, 4'd0, 4'd0, DIR_NORTH, 4'd0, 16'd0);
    push_req(REQ_QUERY, 4'd7, 4'd7, DIR_NORTH, 4'd0, 16'd0);
    push_req(REQ_UNKNOWN_LO, 4'd15, 4'd15, DIR_WEST, 4'd15, 16'd5);
    push_req(REQ_UNKNOWN_HI, 4'd0, 4'd15, DIR_EAST, 4'd0, COST_TOP);
    push_req(REQ_SET_COST, 4'd7, 4'd8, DIR_NORTH, 4'd0, 16'd0);
    push_req(REQ_SET_COST, 4'd8, 4'd7, DIR_NORTH, 4'd0, COST_TOP);
    push_req(REQ_SET_COST, 4'd6, 4'd7, DIR_NORTH, 4'd0, 16'h8000);
    push_req(REQ_UPDATE, 4'd7, 4'd7, DIR_NORTH, 4'd0, 16'd0);
    push_req(REQ_UPDATE, 4'd15, 4'd15, DIR_NORTH, 4'd15, 16'd0);
    push_req(REQ_UPDATE, 4'd0, 4'd0, DIR_NORTH, 4'd0, 16'd0);
    push_req(REQ_ADD_WALL, 4'd0, 4'd15, DIR_EAST, 4'd0, 16'd0);
    push_req(REQ_ADD_WALL, 4'd15, 4'd3, DIR_NORTH, 4'd0, 16'd0);
    push_req(REQ_ADD_WALL, 4'd9, 4'd9, DIR_SOUTH, 4'd0, 16'd0);
    push_req(REQ_ADD_WALL, 4'd9, 4'd9, DIR_WEST, 4'd0, 16'd0);
    push_req(REQ_REMOVE_WALL, 4'd0, 4'd0, DIR_SOUTH, 4'd0, 16'd0);
    push_req(REQ_REMOVE_WALL, 4'd3, 4'd0, DIR_WEST, 4'd0, 16'd0);
    push_req(REQ_REMOVE_WALL, 4'd15, 4'd15, DIR_NORTH, 4'd0, 16'd0);
    push_req(REQ_SET_COST, 4'd2, 4'd1, DIR_NORTH, 4'd0, COST_TOP);
    push_req(REQ_SET_COST, 4'd1, 4'd2, DIR_NORTH, 4'd0, COST_TOP);
    push_req(REQ_SET_COST, 4'd0, 4'd1, DIR_NORTH, 4'd0, COST_TOP);
    push_req(REQ_SET_COST, 4'd1, 4'd0, DIR_NORTH, 4'd0, COST_TOP);
    push_req(REQ_UPDATE, 4'd1, 4'd1, DIR_NORTH, 4'd0, 16'd0);
    push_req(REQ_QUERY, 4'd1, 4'd1, DIR_NORTH, 4'd0, 16'd0);
    n_directed = pending_reqs.size();
    tx_enable <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      drain_all();
      case (phase)
        0: begin
          g_row = 0;
          g_col = 0;
        end
        1: begin
          g_row = 15;
          g_col = 15;
        end
        default: begin
          g_row = $urandom_range(15);
          g_col = $urandom_range(15);
        end
      endcase
      apb_transfer(1'b1, ADDR_GOAL_ROW, 4'(g_row));
      apb_transfer(1'b1, ADDR_GOAL_COL, 4'(g_col));
      apb_transfer(1'b0, ADDR_GOAL_ROW, 4'd0);
      apb_transfer(1'b0, ADDR_GOAL_COL, 4'd0);
      no_gaps <= (phase == 1);
      win_row = (phase == 1) ? 4'd14 : 4'($urandom_range(15));
      win_col = (phase == 1) ? 4'd14 : 4'($urandom_range(15));
      repeat (PHASE_ITEMS) pending_reqs.push_back(random_req());
    end
    drain_all();

    $display("covered %0d requests (%0d directed) under four goal settings,", n_sent,
             n_directed);
    $display("%0d results checked, %0d of them on the goal cell", n_checked, n_goal_hits);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
